@@ hdl/riff_wave_chunk_parser_top_defines.svh @@
// ---------------------------------------------------------------------------
// RIFF/WAVE chunk parser assertion macros
// Concurrent check wrappers, compiled away for synthesis.
// ---------------------------------------------------------------------------
`ifndef RIFF_WAVE_CHUNK_PARSER_TOP_DEFINES_SVH
`define RIFF_WAVE_CHUNK_PARSER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define RWCP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define RWCP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RWCP_ASSERT_SAME(label, ante, cons, msg)
`define RWCP_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

@@ hdl/rwcp_pkg.sv @@
// ---------------------------------------------------------------------------
// RIFF/WAVE chunk parser package
// Parse phases, chunk kinds, status codes, tags and the result item type.
// ---------------------------------------------------------------------------
package rwcp_pkg;

	typedef enum logic [4:0] {
		PH_FILE_HEADER  = 5'b00001,
		PH_CHUNK_HEADER = 5'b00010,
		PH_BODY         = 5'b00100,
		PH_PAD          = 5'b01000,
		PH_HALTED       = 5'b10000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_OTHER = 2'd0,
		KIND_FMT   = 2'd1,
		KIND_DATA  = 2'd2
	} kind_t;

	localparam logic [3:0] ST_OK         = 4'd0;
	localparam logic [3:0] ST_TOO_SMALL  = 4'd1;
	localparam logic [3:0] ST_NOT_RIFF   = 4'd2;
	localparam logic [3:0] ST_CORRUPT    = 4'd3;
	localparam logic [3:0] ST_BAD_FMT    = 4'd4;
	localparam logic [3:0] ST_MISSING    = 4'd5;
	localparam logic [3:0] ST_FORMAT     = 4'd6;
	localparam logic [3:0] ST_DEPTH      = 4'd7;
	localparam logic [3:0] ST_NO_FRAMES  = 4'd8;

	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	localparam logic [31:0] MIN_FILE_BYTES = 32'd44;
	localparam logic [31:0] FMT_MIN_BYTES  = 32'd16;
	localparam logic [4:0]  FMT_FIELD_END  = 5'd16;
	localparam logic [4:0]  HDR_BYTES      = 5'd8;
	localparam logic [4:0]  TAG_BYTES      = 5'd4;
	localparam logic [15:0] FMT_PCM        = 16'd1;
	localparam logic [15:0] FMT_FLOAT      = 16'd3;
	localparam logic [15:0] DEPTH_PCM      = 16'd16;
	localparam logic [15:0] DEPTH_FLOAT    = 16'd32;

	typedef struct packed {
		logic [31:0] data_length;
		logic [15:0] bits_per_sample;
		logic [31:0] sample_rate;
		logic [15:0] channels;
		logic [15:0] audio_format;
		logic [3:0]  status;
		logic [7:0]  pcm_byte;
		logic        data_start;
		logic        is_report;
	} result_t;

endpackage

@@ hdl/riff_wave_chunk_parser_top.sv @@
// ---------------------------------------------------------------------------
// RIFF/WAVE chunk parser
// Walks a WAV byte stream, passes data chunk bytes and reports the header.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one file byte per beat in s_tdata[7:0]; s_tlast
//   marks the final byte of the file.
//   Output stream (m_*): a pcm beat for each data chunk byte, and after the
//   final byte a report beat. m_tuser[0] tells a report from a pcm beat,
//   m_tuser[1] flags the first byte of a data chunk.
//   Each result is written into the result queue when its byte is accepted.
//   Throughput: one byte per cycle while s_tready is high. A data chunk
//   byte that is also the final byte of the file yields two beats; the
//   four-entry result queue absorbs this, and s_tready falls only when fewer
//   than two entries are free.
//   Reset clears all parse state and empties the queue. After each final
//   byte the parser returns to its reset state for the next file.
//   When the receiver stalls, results wait in the queue and input is taken
//   until the queue nears full.
// ---------------------------------------------------------------------------
`include "riff_wave_chunk_parser_top_defines.svh"

module riff_wave_chunk_parser_top
	import rwcp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic         s_tlast,   // end_of_file
	output logic         m_tvalid,
	input  logic         m_tready,
	// [7:0] pcm_byte, [11:8] status, [27:12] audio_format, [43:28] channels,
	// [75:44] sample_rate, [91:76] bits_per_sample, [123:92] data_length,
	// [127:124] zero
	output logic [127:0] m_tdata,
	output logic [1:0]   m_tuser    // [0] is_report, [1] data_start
);

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	logic [31:0] bcnt_q, bcnt_n;
	phase_t      phase_q, phase_n;
	logic [31:0] tag_q, tag_n;
	logic [31:0] rem_q, rem_n;
	logic [4:0]  off_q, off_n;
	kind_t       kind_q, kind_n;
	logic        pad_q, pad_n;
	logic [3:0]  err_q, err_n;
	logic        fpe_q, fpe_n;
	logic [15:0] fmt_q, fmt_n;
	logic [15:0] ch_q, ch_n;
	logic [31:0] rate_q, rate_n;
	logic [15:0] depth_q, depth_n;
	logic [31:0] dlen_q, dlen_n;

	logic        take, pop, fin, pcm_vld;
	logic [3:0]  status;
	logic [17:0] frame_bytes;
	result_t     pcm_res, rep_res, res0, res1, head;
	logic        push0, push1;
	logic [CNT_W-1:0] npush;

	result_t          fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign take = s_tvalid && s_tready;
	assign pop = m_tvalid && m_tready;
	assign s_tready = cnt_q <= CNT_W'(FIFO_DEPTH - 2);

	always_comb begin
		bcnt_n = (bcnt_q != 32'hFFFF_FFFF) ? bcnt_q + 32'd1 : bcnt_q;
		phase_n = phase_q;
		tag_n = tag_q;
		rem_n = rem_q;
		off_n = off_q;
		kind_n = kind_q;
		pad_n = pad_q;
		err_n = err_q;
		fpe_n = fpe_q;
		fmt_n = fmt_q;
		ch_n = ch_q;
		rate_n = rate_q;
		depth_n = depth_q;
		dlen_n = dlen_q;
		fin = 1'b0;
		pcm_vld = 1'b0;
		unique case (phase_q)
			PH_FILE_HEADER: begin
				tag_n = {tag_q[23:0], s_tdata};
				if (bcnt_q == 32'd3 && tag_n != TAG_RIFF) begin
					err_n = ST_NOT_RIFF;
					phase_n = PH_HALTED;
				end else if (bcnt_q == 32'd11) begin
					if (tag_n != TAG_WAVE) begin
						err_n = ST_NOT_RIFF;
						phase_n = PH_HALTED;
					end else begin
						phase_n = PH_CHUNK_HEADER;
						off_n = 5'd0;
					end
				end
			end
			PH_CHUNK_HEADER: begin
				if (off_q < TAG_BYTES) tag_n = {tag_q[23:0], s_tdata};
				else rem_n = {s_tdata, rem_q[31:8]};
				off_n = off_q + 5'd1;
				if (off_n >= HDR_BYTES) begin
					off_n = 5'd0;
					pad_n = rem_n[0];
					fpe_n = 1'b0;
					if (tag_n == TAG_FMT) begin
						kind_n = KIND_FMT;
						fpe_n = rem_n < FMT_MIN_BYTES;
					end else if (tag_n == TAG_DATA) begin
						kind_n = KIND_DATA;
						dlen_n = rem_n;
					end else begin
						kind_n = KIND_OTHER;
					end
					phase_n = PH_BODY;
					fin = rem_n == 32'd0;
				end
			end
			PH_BODY: begin
				if (kind_q == KIND_DATA) begin
					pcm_vld = 1'b1;
				end else if (kind_q == KIND_FMT) begin
					case (off_q)
						5'd0:  fmt_n = {8'd0, s_tdata};
						5'd1:  fmt_n = {s_tdata, fmt_q[7:0]};
						5'd2:  ch_n = {8'd0, s_tdata};
						5'd3:  ch_n = {s_tdata, ch_q[7:0]};
						5'd4:  rate_n = {24'd0, s_tdata};
						5'd5:  rate_n = {16'd0, s_tdata, rate_q[7:0]};
						5'd6:  rate_n = {8'd0, s_tdata, rate_q[15:0]};
						5'd7:  rate_n = {s_tdata, rate_q[23:0]};
						5'd14: depth_n = {8'd0, s_tdata};
						5'd15: depth_n = {s_tdata, depth_q[7:0]};
						default: ;
					endcase
				end
				if (off_q < FMT_FIELD_END) off_n = off_q + 5'd1;
				rem_n = rem_q - 32'd1;
				fin = rem_n == 32'd0;
			end
			PH_PAD: begin
				phase_n = PH_CHUNK_HEADER;
				off_n = 5'd0;
			end
			PH_HALTED: ;
			default: ;
		endcase
		if (fin) begin
			if (fpe_n) begin
				err_n = ST_BAD_FMT;
				phase_n = PH_HALTED;
			end else begin
				off_n = 5'd0;
				phase_n = pad_n ? PH_PAD : PH_CHUNK_HEADER;
			end
		end
	end

	always_comb begin
		frame_bytes = (fmt_n == FMT_PCM) ? {1'b0, ch_n, 1'b0} : {ch_n, 2'b00};
		if (bcnt_n < MIN_FILE_BYTES) status = ST_TOO_SMALL;
		else if (err_n != ST_OK) status = err_n;
		else if (phase_n == PH_BODY && rem_n != 32'd0) status = ST_CORRUPT;
		else if (ch_n == 16'd0 || rate_n == 32'd0 || depth_n == 16'd0 || dlen_n == 32'd0)
			status = ST_MISSING;
		else if (fmt_n != FMT_PCM && fmt_n != FMT_FLOAT) status = ST_FORMAT;
		else if (!((fmt_n == FMT_PCM && depth_n == DEPTH_PCM) ||
				(fmt_n == FMT_FLOAT && depth_n == DEPTH_FLOAT)))
			status = ST_DEPTH;
		else if (dlen_n < {14'd0, frame_bytes}) status = ST_NO_FRAMES;
		else status = ST_OK;
	end

	always_comb begin
		pcm_res = '0;
		pcm_res.pcm_byte = s_tdata;
		pcm_res.data_start = off_q == 5'd0;
		rep_res = '0;
		rep_res.is_report = 1'b1;
		rep_res.status = status;
		rep_res.audio_format = fmt_n;
		rep_res.channels = ch_n;
		rep_res.sample_rate = rate_n;
		rep_res.bits_per_sample = depth_n;
		rep_res.data_length = dlen_n;
		res0 = pcm_vld ? pcm_res : rep_res;
		res1 = rep_res;
		push0 = pcm_vld || s_tlast;
		push1 = pcm_vld && s_tlast;
		npush = CNT_W'(push0) + CNT_W'(push1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcnt_q <= '0;
			phase_q <= PH_FILE_HEADER;
			tag_q <= '0;
			rem_q <= '0;
			off_q <= '0;
			kind_q <= KIND_OTHER;
			pad_q <= 1'b0;
			err_q <= ST_OK;
			fpe_q <= 1'b0;
			fmt_q <= '0;
			ch_q <= '0;
			rate_q <= '0;
			depth_q <= '0;
			dlen_q <= '0;
		end else if (take) begin
			if (s_tlast) begin
				bcnt_q <= '0;
				phase_q <= PH_FILE_HEADER;
				tag_q <= '0;
				rem_q <= '0;
				off_q <= '0;
				kind_q <= KIND_OTHER;
				pad_q <= 1'b0;
				err_q <= ST_OK;
				fpe_q <= 1'b0;
				fmt_q <= '0;
				ch_q <= '0;
				rate_q <= '0;
				depth_q <= '0;
				dlen_q <= '0;
			end else begin
				bcnt_q <= bcnt_n;
				phase_q <= phase_n;
				tag_q <= tag_n;
				rem_q <= rem_n;
				off_q <= off_n;
				kind_q <= kind_n;
				pad_q <= pad_n;
				err_q <= err_n;
				fpe_q <= fpe_n;
				fmt_q <= fmt_n;
				ch_q <= ch_n;
				rate_q <= rate_n;
				depth_q <= depth_n;
				dlen_q <= dlen_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && push0) fifo_q[wr_ptr_q] <= res0;
		if (take && push1) fifo_q[wr_ptr_q + PTR_W'(1)] <= res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (take) wr_ptr_q <= wr_ptr_q + PTR_W'(npush);
			if (pop) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			cnt_q <= cnt_q + (take ? npush : CNT_W'(0)) - CNT_W'(pop);
		end
	end

	assign head = fifo_q[rd_ptr_q];
	assign m_tvalid = cnt_q != '0;
	assign m_tuser = {head.data_start, head.is_report};
	assign m_tdata = {4'd0, head.data_length, head.bits_per_sample, head.sample_rate,
		head.channels, head.audio_format, head.status, head.pcm_byte};

	`RWCP_ASSERT_SAME(a_queue_bound, 1'b1, cnt_q <= CNT_W'(FIFO_DEPTH), "result queue overflow")
	`RWCP_ASSERT_NEXT(a_eof_restart, take && s_tlast, phase_q == PH_FILE_HEADER && bcnt_q == 32'd0, "no restart after final byte")
	`RWCP_ASSERT_SAME(a_halt_has_error, phase_q == PH_HALTED, err_q != ST_OK, "halted without error code")
	`RWCP_ASSERT_SAME(a_pcm_no_status, m_tvalid && !m_tuser[0], m_tdata[11:8] == ST_OK, "pcm beat carries status")

endmodule

@@ dv/tb_riff_wave_chunk_parser_top.sv @@
// ---------------------------------------------------------------------------
// RIFF/WAVE chunk parser testbench
// Streams directed and randomly built WAV files through the parser, byte per
// beat, with random gaps on both sides, and checks every pcm and report beat
// against a cycle-free model of the header walk kept in step with the input.
// ---------------------------------------------------------------------------
module tb_riff_wave_chunk_parser_top
	import rwcp_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [31:0] TAG_LIST = 32'h4C49_5354;
	localparam int          DIR_BEATS = 21;

	typedef struct packed {
		logic        is_report;
		logic        data_start;
		logic [7:0]  pcm;
		logic [3:0]  status;
		logic [15:0] audio_format;
		logic [15:0] channels;
		logic [31:0] sample_rate;
		logic [15:0] depth;
		logic [31:0] data_length;
	} wav_result_t;

	typedef enum int {
		FK_GOOD_PCM,
		FK_GOOD_FLOAT,
		FK_RANDOM_FMT,
		FK_SHORT_FMT,
		FK_SHORT_FMT_EOF,
		FK_EMPTY_DATA,
		FK_TWO_DATA,
		FK_NO_FRAMES,
		FK_ODD_SIZES,
		FK_TRUNCATED,
		FK_BAD_TAG,
		FK_NOISE,
		FK_COUNT
	} file_kind_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = 8'h00;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;
	logic [1:0]   m_tuser;

	wav_result_t results_due [$];
	logic [7:0]  file_bytes [$];
	int          errors = 0;
	bit          calm = 1'b0;

	// parser state mirror
	logic [31:0] byte_count;
	phase_t      phase;
	logic [31:0] tag;
	logic [31:0] remain;
	logic [4:0]  offset;
	kind_t       cur_kind;
	logic        pad_due;
	logic [3:0]  err;
	logic        fmt_err;
	logic [15:0] fmt_reg;
	logic [15:0] ch_reg;
	logic [31:0] rate_reg;
	logic [15:0] depth_reg;
	logic [31:0] dlen_reg;

	// short files: all of these report too small
	logic [7:0] dir_byte [DIR_BEATS] = '{
		8'h00, 8'hFF,
		8'h52, 8'h49, 8'h46, 8'h46, 8'h24, 8'h00, 8'h00, 8'h00, 8'h57, 8'h41, 8'h56, 8'h45,
		8'h52, 8'h49, 8'h46, 8'h58, 8'h41,
		8'h55, 8'hAA
	};
	logic       dir_last [DIR_BEATS] = '{
		1'b1, 1'b1,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
		1'b0, 1'b1
	};
	logic [3:0] dir_status [DIR_BEATS] = '{
		ST_TOO_SMALL, ST_TOO_SMALL,
		ST_OK, ST_OK, ST_OK, ST_OK, ST_OK, ST_OK, ST_OK, ST_OK, ST_OK, ST_OK, ST_OK,
		ST_TOO_SMALL,
		ST_OK, ST_OK, ST_OK, ST_OK, ST_TOO_SMALL,
		ST_OK, ST_TOO_SMALL
	};

	riff_wave_chunk_parser_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			flag_mismatch(what, got, want);
	endtask

	task automatic clear_parser();
		byte_count = '0;
		phase = PH_FILE_HEADER;
		tag = '0;
		remain = '0;
		offset = '0;
		cur_kind = KIND_OTHER;
		pad_due = 1'b0;
		err = ST_OK;
		fmt_err = 1'b0;
		fmt_reg = '0;
		ch_reg = '0;
		rate_reg = '0;
		depth_reg = '0;
		dlen_reg = '0;
	endtask

	task automatic halt(input logic [3:0] code);
		err = code;
		phase = PH_HALTED;
	endtask

	task automatic close_body();
		if (fmt_err) begin
			halt(ST_BAD_FMT);
		end else begin
			offset = '0;
			phase = pad_due ? PH_PAD : PH_CHUNK_HEADER;
		end
	endtask

	function automatic logic [3:0] report_status();
		logic [31:0] frame_bytes;
		frame_bytes = {16'h0, depth_reg / 16'd8} * {16'h0, ch_reg};
		if (byte_count < MIN_FILE_BYTES)
			return ST_TOO_SMALL;
		if (err != ST_OK)
			return err;
		if (phase == PH_BODY && remain != 0)
			return ST_CORRUPT;
		if (ch_reg == 0 || rate_reg == 0 || depth_reg == 0 || dlen_reg == 0)
			return ST_MISSING;
		if (fmt_reg != FMT_PCM && fmt_reg != FMT_FLOAT)
			return ST_FORMAT;
		if (!((fmt_reg == FMT_PCM && depth_reg == DEPTH_PCM) ||
				(fmt_reg == FMT_FLOAT && depth_reg == DEPTH_FLOAT)))
			return ST_DEPTH;
		if (dlen_reg < frame_bytes)
			return ST_NO_FRAMES;
		return ST_OK;
	endfunction

	task automatic parse_byte(input logic [7:0] b, input logic last);
		logic [31:0] idx;
		wav_result_t r;
		idx = byte_count;
		if (byte_count != '1)
			byte_count++;
		case (phase)
			PH_FILE_HEADER: begin
				tag = {tag[23:0], b};
				if (idx == 3 && tag != TAG_RIFF) begin
					halt(ST_NOT_RIFF);
				end else if (idx == 11) begin
					if (tag != TAG_WAVE) begin
						halt(ST_NOT_RIFF);
					end else begin
						phase = PH_CHUNK_HEADER;
						offset = '0;
					end
				end
			end
			PH_CHUNK_HEADER: begin
				if (offset < TAG_BYTES)
					tag = {tag[23:0], b};
				else
					remain = {b, remain[31:8]};
				offset++;
				if (offset >= HDR_BYTES) begin
					offset = '0;
					pad_due = remain[0];
					fmt_err = 1'b0;
					if (tag == TAG_FMT) begin
						cur_kind = KIND_FMT;
						fmt_err = remain < FMT_MIN_BYTES;
					end else if (tag == TAG_DATA) begin
						cur_kind = KIND_DATA;
						dlen_reg = remain;
					end else begin
						cur_kind = KIND_OTHER;
					end
					phase = PH_BODY;
					if (remain == 0)
						close_body();
				end
			end
			PH_BODY: begin
				if (cur_kind == KIND_DATA) begin
					r = '0;
					r.pcm = b;
					r.data_start = (offset == 0);
					results_due.push_back(r);
				end else if (cur_kind == KIND_FMT) begin
					case (offset)
						5'd0:  fmt_reg = {8'h00, b};
						5'd1:  fmt_reg[15:8] = b;
						5'd2:  ch_reg = {8'h00, b};
						5'd3:  ch_reg[15:8] = b;
						5'd4:  rate_reg = {24'h0, b};
						5'd5:  rate_reg[15:8] = b;
						5'd6:  rate_reg[23:16] = b;
						5'd7:  rate_reg[31:24] = b;
						5'd14: depth_reg = {8'h00, b};
						5'd15: depth_reg[15:8] = b;
						default: ;
					endcase
				end
				if (offset < FMT_FIELD_END)
					offset++;
				remain--;
				if (remain == 0)
					close_body();
			end
			PH_PAD: begin
				phase = PH_CHUNK_HEADER;
				offset = '0;
			end
			default: ;
		endcase
		if (last) begin
			r = '0;
			r.is_report = 1'b1;
			r.status = report_status();
			r.audio_format = fmt_reg;
			r.channels = ch_reg;
			r.sample_rate = rate_reg;
			r.depth = depth_reg;
			r.data_length = dlen_reg;
			results_due.push_back(r);
			clear_parser();
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last);
		while (!calm && $urandom_range(0, 99) < 13) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		parse_byte(b, last);
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic put_tag(input logic [31:0] t);
		file_bytes.push_back(t[31:24]);
		file_bytes.push_back(t[23:16]);
		file_bytes.push_back(t[15:8]);
		file_bytes.push_back(t[7:0]);
	endtask

	task automatic put_le32(input logic [31:0] v);
		for (int k = 0; k < 4; k++)
			file_bytes.push_back(v[8*k +: 8]);
	endtask

	task automatic put_chunk(input logic [31:0] t, input logic [31:0] len);
		put_tag(t);
		put_le32(len);
		repeat (len)
			file_bytes.push_back(8'($urandom));
		if (len[0])
			file_bytes.push_back(8'($urandom));
	endtask

	task automatic build_file(input file_kind_t fk);
		logic [7:0]  fmt_body [18];
		logic [31:0] fmt_size;
		logic [31:0] cut;
		logic [15:0] f_format;
		logic [15:0] f_ch;
		logic [15:0] f_depth;
		logic [31:0] f_rate;
		int          pos;
		int          body_at;
		file_bytes.delete();
		cut = 0;
		if (fk == FK_NOISE) begin
			repeat ($urandom_range(1, 70))
				file_bytes.push_back(8'($urandom));
			return;
		end
		put_tag(TAG_RIFF);
		put_le32($urandom);
		put_tag(TAG_WAVE);
		if (fk == FK_BAD_TAG) begin
			pos = $urandom_range(0, 7);
			if (pos >= 4)
				pos += 4;
			file_bytes[pos] ^= 8'(1 << $urandom_range(0, 7));
		end
		if (fk == FK_SHORT_FMT_EOF)
			put_chunk(TAG_LIST, 24);
		else if (fk == FK_ODD_SIZES)
			put_chunk(TAG_LIST, 2 * $urandom_range(0, 4) + 1);
		else if ($urandom_range(0, 3) == 0)
			put_chunk($urandom_range(0, 1) ? TAG_LIST : $urandom, $urandom_range(0, 9));

		f_format = FMT_PCM;
		f_ch = 16'($urandom_range(1, 2));
		f_rate = $urandom_range(0, 1) ? 32'd44100 : 32'd48000;
		f_depth = DEPTH_PCM;
		fmt_size = 16;
		case (fk)
			FK_GOOD_FLOAT: begin
				f_format = FMT_FLOAT;
				f_ch = 16'($urandom_range(1, 8));
				f_rate = $urandom | 32'd1;
				f_depth = DEPTH_FLOAT;
			end
			FK_RANDOM_FMT: begin
				if ($urandom_range(0, 3) == 0)
					f_format = 16'($urandom);
				else
					f_format = $urandom_range(0, 1) ? FMT_PCM : FMT_FLOAT;
				f_ch = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
				f_rate = ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom;
				case ($urandom_range(0, 5))
					0: f_depth = 16'd0;
					1: f_depth = 16'd8;
					2: f_depth = DEPTH_PCM;
					3: f_depth = 16'd24;
					4: f_depth = DEPTH_FLOAT;
					default: f_depth = 16'($urandom);
				endcase
				fmt_size = $urandom_range(0, 1) ? 16 : 18;
			end
			FK_SHORT_FMT:     fmt_size = $urandom_range(0, 15);
			FK_SHORT_FMT_EOF: fmt_size = $urandom_range(2, 15);
			FK_ODD_SIZES:     fmt_size = $urandom_range(17, 18);
			FK_NO_FRAMES: begin
				f_ch = 16'd2;
				f_rate = 32'd8000;
			end
			default: ;
		endcase
		fmt_body[0] = f_format[7:0];
		fmt_body[1] = f_format[15:8];
		fmt_body[2] = f_ch[7:0];
		fmt_body[3] = f_ch[15:8];
		for (int k = 0; k < 4; k++)
			fmt_body[4 + k] = f_rate[8*k +: 8];
		for (int k = 8; k < 14; k++)
			fmt_body[k] = 8'($urandom);
		fmt_body[14] = f_depth[7:0];
		fmt_body[15] = f_depth[15:8];
		fmt_body[16] = 8'($urandom);
		fmt_body[17] = 8'($urandom);
		put_tag(TAG_FMT);
		put_le32(fmt_size);
		body_at = file_bytes.size();
		for (int k = 0; k < fmt_size; k++)
			file_bytes.push_back(fmt_body[k]);
		if (fmt_size[0])
			file_bytes.push_back(8'($urandom));
		if (fk == FK_SHORT_FMT_EOF)
			cut = body_at + $urandom_range(1, fmt_size - 1);

		case (fk)
			FK_EMPTY_DATA: put_chunk(TAG_DATA, 0);
			FK_NO_FRAMES:  put_chunk(TAG_DATA, $urandom_range(1, 3));
			FK_ODD_SIZES:  put_chunk(TAG_DATA, 2 * $urandom_range(0, 5) + 1);
			FK_TWO_DATA: begin
				put_chunk(TAG_DATA, $urandom_range(1, 8));
				if ($urandom_range(0, 1))
					put_chunk(TAG_LIST, $urandom_range(0, 5));
				put_chunk(TAG_DATA, $urandom_range(1, 8));
			end
			default: put_chunk(TAG_DATA, $urandom_range(1, 12));
		endcase
		if ($urandom_range(0, 3) == 0)
			put_chunk(TAG_LIST, $urandom_range(0, 7));
		if (fk == FK_TRUNCATED)
			cut = $urandom_range(12, file_bytes.size() - 1);
		if (cut != 0)
			while (file_bytes.size() > cut)
				void'(file_bytes.pop_back());
	endtask

	always @(posedge clk) begin : rx_side
		wav_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					flag_mismatch("beat with nothing due", 32'd1, 32'd0);
				end else begin
					want = results_due.pop_front();
					check_field("is_report", m_tuser[0], want.is_report);
					check_field("data_start", m_tuser[1], want.data_start);
					check_field("pcm_byte", m_tdata[7:0], want.pcm);
					check_field("status", m_tdata[11:8], want.status);
					check_field("audio_format", m_tdata[27:12], want.audio_format);
					check_field("channels", m_tdata[43:28], want.channels);
					check_field("sample_rate", m_tdata[75:44], want.sample_rate);
					check_field("bits_per_sample", m_tdata[91:76], want.depth);
					check_field("data_length", m_tdata[123:92], want.data_length);
				end
			end
			m_tready <= calm || ($urandom_range(0, 99) >= 13);
		end
	end

	initial begin
		wav_result_t typed;
		file_kind_t  fk;
		int          sent;
		int          file_no;
		clear_parser();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_BEATS; i++) begin
			send_byte(dir_byte[i], dir_last[i]);
			if (dir_last[i]) begin
				typed = '0;
				typed.is_report = 1'b1;
				typed.status = dir_status[i];
				results_due[results_due.size() - 1] = typed;
			end
		end

		sent = 0;
		file_no = 0;
		while (sent < 700) begin
			if (file_no < FK_COUNT)
				fk = file_kind_t'(file_no);
			else
				fk = file_kind_t'($urandom_range(0, FK_COUNT - 1));
			build_file(fk);
			if (file_no == 6)
				calm = 1'b1;
			if (file_no == 10)
				calm = 1'b0;
			foreach (file_bytes[i])
				send_byte(file_bytes[i], i == file_bytes.size() - 1);
			sent += file_bytes.size();
			// hold the sender until the parser has drained
			if (file_no == 4) begin
				s_tvalid <= 1'b0;
				while (results_due.size() != 0)
					@(posedge clk);
			end
			file_no++;
		end
		s_tvalid <= 1'b0;

		while (results_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#5ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
